// ===== hw/rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types, command and status codes, and the record ordering function
// of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_RENAME = 3'd2;
  localparam logic [2:0] KIND_SORT   = 3'd3;
  localparam logic [2:0] KIND_LIST   = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_CANCELLED = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_SHIFT,
    RING_SORT
  } ring_mode_t;

  typedef struct packed {
    ring_mode_t mode;
    logic       phase;
  } ring_ctl_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] id;
    logic [63:0]        th;
    logic [47:0]        tl;
  } rec_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] key_id;
    logic [63:0]        text_high;
    logic [47:0]        text_low;
    logic               confirm;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         slot;
    logic signed [31:0] entry_id;
    logic [63:0]        entry_text_high;
    logic [47:0]        entry_text_low;
    logic               last;
  } out_t;

  // True when record a orders after record b: name, then signed id, then
  // valid mark.
  function automatic logic rec_after(input rec_t a, input rec_t b);
    logic res;
    if (a.th != b.th) begin
      res = (a.th > b.th);
    end else if (a.tl != b.tl) begin
      res = (a.tl > b.tl);
    end else if (a.id != b.id) begin
      res = (a.id > b.id);
    end else begin
      res = (a.vld && !b.vld);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/krt_cell.sv =====
// ----------------------------------------------------------------------------
// krt_cell
// One slot of the record ring. It holds a record and either keeps it, takes
// its neighbor's record in a rotation, or exchanges with its sort partner.
// ----------------------------------------------------------------------------
module krt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  krt_pkg::ring_ctl_t ctl,
  input  krt_pkg::rec_t     shift_in,
  input  krt_pkg::rec_t     partner,
  input  logic              lower,
  input  logic              pair_ok,
  output krt_pkg::rec_t     rec
);

  krt_pkg::rec_t rec_r;
  krt_pkg::rec_t rec_nxt;
  logic          swap;

  always_comb begin
    swap = 1'b0;
    if (pair_ok) begin
      swap = lower ? krt_pkg::rec_after(rec_r, partner)
                   : krt_pkg::rec_after(partner, rec_r);
    end
    rec_nxt = rec_r;
    case (ctl.mode)
      krt_pkg::RING_SHIFT: rec_nxt = shift_in;
      krt_pkg::RING_SORT:  if (swap) rec_nxt = partner;
      default:             rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec = rec_r;

endmodule

// ===== hw/rtl/keyed_record_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Fixed table of record slots with insert, remove, rename, sort and list.
// ----------------------------------------------------------------------------
// Usage: one command item enters on the in_ channel (valid/ready) and the
// block answers on the out_ channel (valid/ready). Insert, remove, rename and
// sort give one result item each; list gives one item per valid slot in slot
// order, or a single table-empty item. Kinds 5 to 7 give no result.
// The slots form a ring of cells. Insert, remove, rename and list rotate the
// ring one slot per cycle, except while a held list result pauses it, until
// each slot has passed the head once, so the slot at the head in step k is
// the original slot k; the command acts on the head as it passes. Sort runs
// SLOTS rounds of odd-even exchange between neighboring cells. The final
// result is handed over in ST_FIN once the output register is free, and
// in_ready is high only while the block is idle, with no command in flight.
// When the receiver stalls during a list, the ring pauses until the held
// result item is taken, so no item is dropped.
// Reset clears all slots (valid marks, ids and names) to zero at once and
// empties the output register; there is no clearing pass.
// ----------------------------------------------------------------------------
module keyed_record_table_unit #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  krt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output krt_pkg::out_t out_data
);

  localparam int CW = (SLOTS > 2) ? $clog2(SLOTS) : 1;

  krt_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  krt_pkg::in_t     cmd_r, cmd_nxt;
  krt_pkg::out_t    pend_r, pend_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  krt_pkg::out_t    out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  krt_pkg::ring_ctl_t ctl;
  krt_pkg::rec_t      cell_rec [SLOTS];
  krt_pkg::rec_t      tail_in;
  krt_pkg::out_t      head_res;
  logic               hit;
  logic               out_free;
  logic               step;

  // The record at the head of the ring is examined each rotation step; the
  // possibly modified copy re-enters at the tail.
  always_comb begin
    krt_pkg::rec_t hd;
    hd       = cell_rec[0];
    tail_in  = hd;
    hit      = 1'b0;
    head_res = '0;
    head_res.slot = 3'(cnt_r);
    case (cmd_r.kind)
      krt_pkg::KIND_INSERT: begin
        if (!pend_vld_r && !hd.vld) begin
          hit     = 1'b1;
          tail_in = '{vld: 1'b1, id: cmd_r.key_id, th: cmd_r.text_high,
                      tl: cmd_r.text_low};
          head_res.entry_id        = cmd_r.key_id;
          head_res.entry_text_high = cmd_r.text_high;
          head_res.entry_text_low  = cmd_r.text_low;
          head_res.last            = 1'b1;
        end
      end
      krt_pkg::KIND_REMOVE, krt_pkg::KIND_RENAME: begin
        if (!pend_vld_r && hd.vld && hd.id == cmd_r.key_id) begin
          hit = 1'b1;
          head_res.entry_id        = hd.id;
          head_res.entry_text_high = hd.th;
          head_res.entry_text_low  = hd.tl;
          head_res.last            = 1'b1;
          if (!cmd_r.confirm) begin
            head_res.status = krt_pkg::STAT_CANCELLED;
          end else if (cmd_r.kind == krt_pkg::KIND_REMOVE) begin
            tail_in.vld = 1'b0;
          end else begin
            tail_in.th               = cmd_r.text_high;
            tail_in.tl               = cmd_r.text_low;
            head_res.entry_text_high = cmd_r.text_high;
            head_res.entry_text_low  = cmd_r.text_low;
          end
        end
      end
      krt_pkg::KIND_LIST: begin
        if (hd.vld) begin
          hit = 1'b1;
          head_res.entry_id        = hd.id;
          head_res.entry_text_high = hd.th;
          head_res.entry_text_low  = hd.tl;
        end
      end
      default: hit = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  // A list result found while an earlier one waits must push that one out.
  assign step     = (state_r == krt_pkg::ST_RUN) && !(hit && pend_vld_r && !out_free);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl.mode      = krt_pkg::RING_HOLD;
    ctl.phase     = cnt_r[0];
    unique case (state_r)
      krt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data;
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          if (in_data.kind <= krt_pkg::KIND_LIST) state_nxt = krt_pkg::ST_RUN;
        end
      end
      krt_pkg::ST_RUN: begin
        if (step) begin
          ctl.mode = (cmd_r.kind == krt_pkg::KIND_SORT) ? krt_pkg::RING_SORT
                                                        : krt_pkg::RING_SHIFT;
          if (hit) begin
            if (pend_vld_r) begin
              out_nxt       = pend_r;
              out_valid_nxt = 1'b1;
            end
            pend_nxt     = head_res;
            pend_vld_nxt = 1'b1;
          end
          if (cnt_r == CW'(SLOTS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = krt_pkg::ST_FIN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      krt_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          if (pend_vld_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            case (cmd_r.kind)
              krt_pkg::KIND_INSERT: out_nxt.status = krt_pkg::STAT_FULL;
              krt_pkg::KIND_REMOVE,
              krt_pkg::KIND_RENAME: out_nxt.status = krt_pkg::STAT_NOT_FOUND;
              krt_pkg::KIND_LIST:   out_nxt.status = krt_pkg::STAT_EMPTY;
              default:              out_nxt.status = krt_pkg::STAT_OK;
            endcase
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = krt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = krt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krt_pkg::ST_IDLE;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Ring of slot cells. Cell i rotates toward cell i-1; in a sort round cell i
  // pairs with its right neighbor when its index parity equals the phase.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    krt_pkg::rec_t sh_in, left_rec, right_rec;
    logic          lower;
    if (i < SLOTS - 1) begin : g_r
      assign sh_in     = cell_rec[i+1];
      assign right_rec = cell_rec[i+1];
    end else begin : g_t
      assign sh_in     = tail_in;
      assign right_rec = cell_rec[i];
    end
    if (i > 0) begin : g_l
      assign left_rec = cell_rec[i-1];
    end else begin : g_h
      assign left_rec = cell_rec[i];
    end
    assign lower = (ctl.phase == 1'(i % 2));
    krt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_in (sh_in),
      .partner  (lower ? right_rec : left_rec),
      .lower    (lower),
      .pair_ok  (lower ? (i < SLOTS - 1) : (i > 0)),
      .rec      (cell_rec[i])
    );
  end

  assign in_ready  = (state_r == krt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == krt_pkg::ST_IDLE) |-> (cnt_r == '0))
    else $error("step counter not cleared while idle");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind <= krt_pkg::KIND_LIST)
      |=> (state_r == krt_pkg::ST_RUN))
    else $error("accepted command did not start");

endmodule
